### sv/sstf_disk_scheduler_top_assert.svh
// assertion macros for the scheduler top level
`ifndef SSTF_DISK_SCHEDULER_TOP_ASSERT_SVH
`define SSTF_DISK_SCHEDULER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SSTF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SSTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sstf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sstf_pkg;

  localparam int unsigned TRACK_W = 16;

  typedef logic [TRACK_W-1:0] track_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_BATCH_INIT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SERVE_RD,
    ST_SERVE_CMP
  } state_e;

  // results of the shared compare and subtract unit
  typedef struct packed {
    logic   a_gt_ref;
    logic   b_lt_ref;
    logic   take_hi;
    track_t seek_len;
  } cmp_res_t;

endpackage

`default_nettype wire

### sv/sstf_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module sstf_mem #(
  parameter int unsigned AW = 5
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire sstf_pkg::track_t wdata_i,
  input  wire logic [AW-1:0]   raddr_a_i,
  input  wire logic [AW-1:0]   raddr_b_i,
  output sstf_pkg::track_t     rdata_a_o,
  output sstf_pkg::track_t     rdata_b_o
);

  localparam int unsigned DEPTH = 1 << AW;

  sstf_pkg::track_t mem_q [DEPTH];
  sstf_pkg::track_t rdata_a_q;
  sstf_pkg::track_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

### sv/sstf_cmp_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module sstf_cmp_unit (
  input  wire sstf_pkg::track_t a_i,
  input  wire sstf_pkg::track_t b_i,
  input  wire sstf_pkg::track_t ref_i,
  input  wire logic        have_lo_i,
  input  wire logic        have_hi_i,
  output sstf_pkg::cmp_res_t res_o
);

  sstf_pkg::track_t dist_lo;
  sstf_pkg::track_t dist_hi;
  logic             take_hi;

  // while serving, the lower neighbour never lies above the head and the upper never below
  assign dist_lo = ref_i - a_i;
  assign dist_hi = b_i - ref_i;

  // ties go to the lower track
  assign take_hi = (have_lo_i && have_hi_i) ? (dist_hi < dist_lo) : have_hi_i;

  assign res_o.a_gt_ref = a_i > ref_i;
  assign res_o.b_lt_ref = b_i < ref_i;
  assign res_o.take_hi  = take_hi;
  assign res_o.seek_len = take_hi ? dist_hi : dist_lo;

endmodule

`default_nettype wire

### sv/sstf_disk_scheduler_top.sv
// insertion: one memory read and compare per step, each larger entry shifted up a slot
// batch start: BATCH_INIT, then the head search reads and compares each stored request
// below the start track in turn (SCAN_RD, SCAN_CMP)
// each result: SERVE_RD reads the pair, SERVE_CMP compares and emits once output is free
// reset clears the counters, head, start track and output valid; the store is not cleared
`timescale 1ns / 1ps
`default_nettype none

module sstf_disk_scheduler_top #(
  parameter int unsigned MAX_REQUESTS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] request_track_i,
  input  wire logic        last_request_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      next_track_o,
  output logic [15:0]      seek_distance_o,
  output logic             last_result_o
);

  localparam int unsigned AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_REQUESTS);
  localparam logic [CW-1:0] ONE = CW'(1);

  sstf_pkg::state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] lo_q, lo_d;
  logic [CW-1:0] hi_q, hi_d;
  logic [CW-1:0] served_q, served_d;
  sstf_pkg::track_t head_q, head_d;
  sstf_pkg::track_t start_q;
  sstf_pkg::track_t trk_q, trk_d;
  logic             last_q, last_d;

  logic             out_valid_q, out_valid_d;
  sstf_pkg::track_t out_track_q, out_track_d;
  sstf_pkg::track_t out_dist_q, out_dist_d;
  logic             out_last_q, out_last_d;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  sstf_pkg::track_t mem_wdata;
  logic [CW-1:0]    raddr_a_full;
  sstf_pkg::track_t rdata_a;
  sstf_pkg::track_t rdata_b;

  sstf_pkg::track_t   cmp_ref;
  logic               have_lo;
  logic               have_hi;
  sstf_pkg::cmp_res_t cmp_res;
  logic               out_free;
  logic               done_ins;

  assign have_lo  = lo_q != '0;
  assign have_hi  = hi_q < count_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign cmp_ref  = (state_q == sstf_pkg::ST_INS_CMP) ? trk_q : head_q;

  // port a looks one below the insert slot or one below the served run
  assign raddr_a_full = ((state_q == sstf_pkg::ST_INS_RD) || (state_q == sstf_pkg::ST_INS_CMP))
                        ? (pos_q - ONE) : (lo_q - ONE);

  sstf_mem #(
    .AW(AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (raddr_a_full[AW-1:0]),
    .raddr_b_i (hi_q[AW-1:0]),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  sstf_cmp_unit u_cmp (
    .a_i       (rdata_a),
    .b_i       (rdata_b),
    .ref_i     (cmp_ref),
    .have_lo_i (have_lo),
    .have_hi_i (have_hi),
    .res_o     (cmp_res)
  );

  // insertion finishes this cycle
  assign done_ins = ((state_q == sstf_pkg::ST_INS_RD) && (pos_q == '0)) ||
                    ((state_q == sstf_pkg::ST_INS_CMP) && !cmp_res.a_gt_ref);

  always_comb begin
    state_d = state_q;
    case (state_q)
      sstf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (count_q < COUNT_MAX) begin
            state_d = sstf_pkg::ST_INS_RD;
          end else if (last_request_i) begin
            state_d = sstf_pkg::ST_BATCH_INIT;
          end
        end
      end
      sstf_pkg::ST_INS_RD,
      sstf_pkg::ST_INS_CMP: begin
        if (done_ins) begin
          state_d = last_q ? sstf_pkg::ST_BATCH_INIT : sstf_pkg::ST_IDLE;
        end else if (state_q == sstf_pkg::ST_INS_RD) begin
          state_d = sstf_pkg::ST_INS_CMP;
        end else begin
          state_d = sstf_pkg::ST_INS_RD;
        end
      end
      sstf_pkg::ST_BATCH_INIT: state_d = sstf_pkg::ST_SCAN_RD;
      sstf_pkg::ST_SCAN_RD: begin
        state_d = (hi_q == count_q) ? sstf_pkg::ST_SERVE_RD : sstf_pkg::ST_SCAN_CMP;
      end
      sstf_pkg::ST_SCAN_CMP: begin
        state_d = cmp_res.b_lt_ref ? sstf_pkg::ST_SCAN_RD : sstf_pkg::ST_SERVE_RD;
      end
      sstf_pkg::ST_SERVE_RD: begin
        state_d = (served_q == count_q) ? sstf_pkg::ST_IDLE : sstf_pkg::ST_SERVE_CMP;
      end
      sstf_pkg::ST_SERVE_CMP: begin
        if (out_free) begin
          state_d = sstf_pkg::ST_SERVE_RD;
        end
      end
      default: state_d = sstf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    pos_d       = pos_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    served_d    = served_q;
    head_d      = head_q;
    trk_d       = trk_q;
    last_d      = last_q;
    out_track_d = out_track_q;
    out_dist_d  = out_dist_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = pos_q[AW-1:0];
    mem_wdata   = trk_q;
    in_ready_o  = 1'b0;
    case (state_q)
      sstf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          trk_d  = request_track_i;
          last_d = last_request_i;
          pos_d  = count_q;
        end
      end
      sstf_pkg::ST_INS_RD,
      sstf_pkg::ST_INS_CMP: begin
        if (done_ins) begin
          mem_we  = 1'b1;
          count_d = count_q + ONE;
        end else if (state_q == sstf_pkg::ST_INS_CMP) begin
          // move the larger entry up one slot
          mem_we    = 1'b1;
          mem_wdata = rdata_a;
          pos_d     = pos_q - ONE;
        end
      end
      sstf_pkg::ST_BATCH_INIT: begin
        head_d   = start_q;
        hi_d     = '0;
        served_d = '0;
      end
      sstf_pkg::ST_SCAN_RD: begin
        if (hi_q == count_q) begin
          lo_d = hi_q;
        end
      end
      sstf_pkg::ST_SCAN_CMP: begin
        if (cmp_res.b_lt_ref) begin
          hi_d = hi_q + ONE;
        end else begin
          lo_d = hi_q;
        end
      end
      sstf_pkg::ST_SERVE_RD: begin
        if (served_q == count_q) begin
          count_d = '0;
        end
      end
      sstf_pkg::ST_SERVE_CMP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_track_d = cmp_res.take_hi ? rdata_b : rdata_a;
          out_dist_d  = cmp_res.seek_len;
          out_last_d  = (served_q + ONE) == count_q;
          head_d      = cmp_res.take_hi ? rdata_b : rdata_a;
          served_d    = served_q + ONE;
          if (cmp_res.take_hi) begin
            hi_d = hi_q + ONE;
          end else begin
            lo_d = lo_q - ONE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sstf_pkg::ST_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      served_q    <= '0;
      head_q      <= '0;
      start_q     <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      served_q    <= served_d;
      head_q      <= head_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        start_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    trk_q       <= trk_d;
    out_track_q <= out_track_d;
    out_dist_q  <= out_dist_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign next_track_o    = out_track_q;
  assign seek_distance_o = out_dist_q;
  assign last_result_o   = out_last_q;

  `include "sstf_disk_scheduler_top_assert.svh"

  `SSTF_ASSERT_NOW(a_count_in_range, 1'b1, count_q <= COUNT_MAX, "request count over capacity")
  `SSTF_ASSERT_NOW(a_run_ordered, (state_q == sstf_pkg::ST_SERVE_RD),
                   (lo_q <= hi_q) && (hi_q <= count_q), "served run out of order")
  `SSTF_ASSERT_NEXT(a_batch_clears, (state_q == sstf_pkg::ST_SERVE_RD) && (served_q == count_q),
                    (count_q == '0) && in_ready_o, "store not emptied after batch")

endmodule

`default_nettype wire

### tb/sstf_disk_scheduler_top_tb.sv
`timescale 1ns / 1ps

module sstf_disk_scheduler_top_tb;

  typedef sstf_pkg::track_t track_t;

  localparam int unsigned MAX_REQUESTS = 32;
  // settle time covers the longest insertion, and a batch start is about as long
  localparam int unsigned SETTLE_CYCLES = 2 * MAX_REQUESTS + 16;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned RANDOM_ITEMS = 80;
  localparam int unsigned QUIET_FROM = 60;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    track_t trk;
    track_t seek_len;
    logic   last;
  } serve_t;

  class seek_scoreboard;
    track_t      sorted_store[MAX_REQUESTS];
    int unsigned stored_count = 0;
    track_t      start_track = '0;
    serve_t      expected_serves[$];
    int unsigned mismatches = 0;

    // serve everything stored, nearest first, ties to the lower track
    function void plan_seek_order();
      int unsigned lo;
      int unsigned hi;
      int unsigned served;
      track_t      head;
      track_t      dl;
      track_t      dh;
      bit          take_hi;
      serve_t      s;
      head = start_track;
      hi = 0;
      while (hi < stored_count && sorted_store[hi] < head) hi++;
      lo = hi;
      for (served = 0; served < stored_count; served++) begin
        if (lo > 0 && hi < stored_count) begin
          dl = head - sorted_store[lo-1];
          dh = sorted_store[hi] - head;
          take_hi = dh < dl;
        end else begin
          take_hi = hi < stored_count;
        end
        if (take_hi) begin
          s.trk = sorted_store[hi];
          s.seek_len = s.trk - head;
          hi++;
        end else begin
          s.trk = sorted_store[lo-1];
          s.seek_len = head - s.trk;
          lo--;
        end
        s.last = (served + 1 == stored_count);
        head = s.trk;
        expected_serves.push_back(s);
      end
      stored_count = 0;
    endfunction

    function void note_request(track_t trk, logic last);
      int unsigned pos;
      // a full store drops the request, the last mark still counts
      if (stored_count < MAX_REQUESTS) begin
        pos = stored_count;
        while (pos > 0 && sorted_store[pos-1] > trk) begin
          sorted_store[pos] = sorted_store[pos-1];
          pos--;
        end
        sorted_store[pos] = trk;
        stored_count++;
      end
      if (last) plan_seek_order();
    endfunction

    function void check_serve(track_t trk, track_t seek_len, logic last);
      serve_t want;
      if (expected_serves.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: track %0d dist %0d last %0b", trk, seek_len, last);
        return;
      end
      want = expected_serves.pop_front();
      if (trk !== want.trk || seek_len !== want.seek_len || last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result mismatch: expected track %0d dist %0d last %0b, got %0d %0d %0b",
                   want.trk, want.seek_len, want.last, trk, seek_len, last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] request_track_i;
  logic        last_request_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] next_track_o;
  logic [15:0] seek_distance_o;
  logic        last_result_o;

  seek_scoreboard sb = new();
  int unsigned    idle_pct = 0;
  bit             long_hold_armed = 1'b0;
  int unsigned    cycle_count = 0;

  sstf_disk_scheduler_top #(
    .MAX_REQUESTS(MAX_REQUESTS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .request_track_i(request_track_i),
    .last_request_i (last_request_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .next_track_o   (next_track_o),
    .seek_distance_o(seek_distance_o),
    .last_result_o  (last_result_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // transfers are sampled with the values seen at the edge
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_valid_i && in_ready_o === 1'b1) sb.note_request(request_track_i, last_request_i);
      if (out_valid_o === 1'b1 && out_ready_i)
        sb.check_serve(next_track_o, seek_distance_o, last_result_o);
    end
  end

  // result side: random stalls, one long hold once a held batch starts serving
  initial begin
    int unsigned gap;
    out_ready_i <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (long_hold_armed && out_valid_o === 1'b1) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        long_hold_armed = 1'b0;
        out_ready_i <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        gap = $urandom_range(1, 13);
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_request(input track_t trk, input logic last);
    int unsigned gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 13);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    request_track_i <= trk;
    last_request_i  <= last;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
  endtask

  task automatic send_list(input track_t trks[$]);
    for (int i = 0; i < trks.size(); i++) send_request(trks[i], i == trks.size() - 1);
  endtask

  function automatic track_t pick_track(track_t near, track_t prev);
    case ($urandom_range(0, 5))
      0, 1:    return track_t'($urandom_range(0, 65535));
      2, 3:    return near + track_t'($urandom_range(0, 64)) - track_t'(32);
      4:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return prev;
    endcase
  endfunction

  task automatic send_random_batch(input int unsigned n, input track_t near);
    track_t prev;
    prev = near;
    for (int unsigned i = 0; i < n; i++) begin
      prev = pick_track(near, prev);
      send_request(prev, i == n - 1);
    end
  endtask

  // non-last requests give no result, so the block may still be inserting
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (sb.expected_serves.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic start_phase(input track_t start);
    drain_and_settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= start;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.start_track = start;
  endtask

  initial begin
    int unsigned random_items;
    int unsigned phase_no;
    int unsigned batches;
    int unsigned n;
    track_t      start;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    in_valid_i      <= 1'b0;
    request_track_i <= '0;
    last_request_i  <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes of track and head
    start_phase(16'h0000);
    send_list('{16'hFFFF, 16'h0000, 16'h0000});
    start_phase(16'hFFFF);
    send_list('{16'h0000, 16'hFFFF, 16'h8000, 16'h0000});
    // equal distance on both sides goes to the lower track
    start_phase(16'd100);
    send_list('{16'd90, 16'd110, 16'd100});
    // single request batches, on the head and far below it
    start_phase(16'd1000);
    send_list('{16'd1000});
    send_list('{16'd5});
    // one side only: all below, then all above
    start_phase(16'd50);
    send_list('{16'd10, 16'd20, 16'd30, 16'd40});
    send_list('{16'd60, 16'd70, 16'd80});

    random_items = 0;
    phase_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 4))
        0:       start = 16'h0000;
        1:       start = 16'hFFFF;
        default: start = track_t'($urandom_range(0, 65535));
      endcase
      start_phase(start);
      if (random_items >= QUIET_FROM) idle_pct = 0;
      else idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
      batches = $urandom_range(2, 4);
      for (int unsigned b = 0; b < batches; b++) begin
        if (phase_no == 0 && b == 0) begin
          // overfull batch with the result side held, more requests queued behind it
          long_hold_armed = 1'b1;
          n = MAX_REQUESTS + 2;
        end else if ($urandom_range(0, 15) == 0) begin
          n = $urandom_range(MAX_REQUESTS, MAX_REQUESTS + 4);
        end else begin
          n = $urandom_range(1, 8);
        end
        send_random_batch(n, start);
        random_items += n;
      end
      phase_no++;
    end

    drain_and_settle();
    if (sb.mismatches == 0 && sb.expected_serves.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/sstf_pkg.sv
sv/sstf_mem.sv
sv/sstf_cmp_unit.sv
sv/sstf_disk_scheduler_top.sv
tb/sstf_disk_scheduler_top_tb.sv
